// ----- design/glr_pkg.sv -----
// shared types and constants of the grid line rasterizer
`default_nettype none

package glr_pkg;

   localparam int KIND_W  = 2;
   localparam int CRD_W   = 7;
   localparam int MAG_W   = 7;
   localparam int DIFF_W  = 8;
   localparam int P_W     = 10;
   localparam int COUNT_W = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_DRAW  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SWEEP  = 6'b000010,
      ST_SETUP  = 6'b000100,
      ST_DRAW   = 6'b001000,
      ST_READ   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic step;
      logic sweep;
      logic load_rsp;
   } glr_cmd_type;

   typedef struct packed {
      logic step_last;
      logic sweep_last;
   } glr_sts_type;

endpackage

`default_nettype wire

// ----- design/glr_if.sv -----
// request and response channel interfaces
`default_nettype none

interface glr_req_if import glr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic signed [CRD_W-1:0] start_x;
   logic signed [CRD_W-1:0] start_y;
   logic signed [CRD_W-1:0] end_x;
   logic signed [CRD_W-1:0] end_y;

   modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface glr_rsp_if import glr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cell_free;
   logic [COUNT_W-1:0] cells_cleared;

   modport source (output valid, cell_free, cells_cleared, input ready);
   modport sink (input valid, cell_free, cells_cleared, output ready);
endinterface

`default_nettype wire

// ----- design/glr_ctrl.sv -----
// sequencing state machine of the grid line rasterizer
`default_nettype none

module glr_ctrl import glr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [KIND_W-1:0] req_kind,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire glr_sts_type       sts,
   output glr_cmd_type            cmd
);

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      reply_in  = reply_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               priority if (req_kind == KIND_DRAW) begin
                  state_in = ST_SETUP;
               end else if (req_kind == KIND_READ) begin
                  state_in = ST_READ;
               end else if (req_kind == KIND_CLEAR) begin
                  state_in = ST_SWEEP;
                  reply_in = 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = reply_ff ? ST_FINISH : ST_IDLE;
               reply_in = 1'b0;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DRAW;
         end
         ST_DRAW: begin
            cmd.step = 1'b1;
            if (sts.step_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/glr_datapath.sv -----
// line stepping datapath and occupancy memory
`default_nettype none

module glr_datapath import glr_pkg::*; #(
   parameter int MAP_SIDE      = 64,
   parameter int CENTRE_OFFSET = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire glr_cmd_type             cmd,
   output glr_sts_type                  sts,
   input  wire logic [KIND_W-1:0]       req_kind,
   input  wire logic signed [CRD_W-1:0] req_start_x,
   input  wire logic signed [CRD_W-1:0] req_start_y,
   input  wire logic signed [CRD_W-1:0] req_end_x,
   input  wire logic signed [CRD_W-1:0] req_end_y,
   output logic                         rsp_cell_free,
   output logic [COUNT_W-1:0]           rsp_cells_cleared
);

   localparam int CELL_W = $clog2(MAP_SIDE);
   localparam int ADDR_W = 2 * CELL_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int POS_W  = $clog2(CENTRE_OFFSET + MAP_SIDE + 128) + 1;

   function automatic logic [POS_W-1:0] place(input logic signed [CRD_W-1:0] v);
      logic signed [POS_W-1:0] wide;
      wide  = POS_W'(v);
      place = wide + POS_W'(CENTRE_OFFSET);
   endfunction

   function automatic logic fits(input logic [POS_W-1:0] pos);
      fits = !pos[POS_W-1] && (pos < POS_W'(MAP_SIDE));
   endfunction

   // captured item
   logic [KIND_W-1:0]       kind_ff;
   logic signed [CRD_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   // line walk
   logic signed [CRD_W-1:0] a_ff, a_in, b_ff, b_in, a_end_ff, a_end_in;
   logic                    steep_ff, steep_in, step_neg_ff, step_neg_in;
   logic signed [P_W-1:0]   p_ff, p_in, inc_lo_ff, inc_lo_in, inc_hi_ff, inc_hi_in;
   logic [COUNT_W-1:0]      count_ff, count_in;

   logic [ADDR_W-1:0]       sweep_addr_ff;
   logic                    rd_bit_ff;
   logic                    cell_free_ff;
   logic [COUNT_W-1:0]      cells_cleared_ff;

   logic                    occ_mem [DEPTH];

   // setup terms
   logic signed [DIFF_W-1:0] ddx, ddy;
   logic [MAG_W-1:0]         dx, dy, major, minor;
   logic                     steep, swap;
   logic signed [CRD_W-1:0]  a1, b1, a2, b2, as_v, bs_v, ae_v, be_v;
   logic signed [P_W-1:0]    two_minor, two_major, p_major;

   // draw point
   logic signed [CRD_W-1:0]  px, py;
   logic [POS_W-1:0]         d_col, d_row, r_col, r_row;
   logic                     d_inside, r_inside;
   logic [ADDR_W-1:0]        d_addr, r_addr, w_addr;
   logic                     mem_we, mem_wd;

   always_comb begin
      ddx       = DIFF_W'(ex_ff) - DIFF_W'(sx_ff);
      ddy       = DIFF_W'(ey_ff) - DIFF_W'(sy_ff);
      dx        = ddx[DIFF_W-1] ? MAG_W'(-ddx) : MAG_W'(ddx);
      dy        = ddy[DIFF_W-1] ? MAG_W'(-ddy) : MAG_W'(ddy);
      steep     = dx < dy;
      a1        = steep ? sy_ff : sx_ff;
      b1        = steep ? sx_ff : sy_ff;
      a2        = steep ? ey_ff : ex_ff;
      b2        = steep ? ex_ff : ey_ff;
      major     = steep ? dy : dx;
      minor     = steep ? dx : dy;
      swap      = a1 > a2;
      as_v      = swap ? a2 : a1;
      bs_v      = swap ? b2 : b1;
      ae_v      = swap ? a1 : a2;
      be_v      = swap ? b1 : b2;
      two_minor = signed'(P_W'({minor, 1'b0}));
      two_major = signed'(P_W'({major, 1'b0}));
      p_major   = signed'(P_W'(major));
   end

   always_comb begin
      px       = steep_ff ? b_ff : a_ff;
      py       = steep_ff ? a_ff : b_ff;
      d_col    = place(px);
      d_row    = place(py);
      d_inside = fits(d_col) && fits(d_row);
      d_addr   = {d_row[CELL_W-1:0], d_col[CELL_W-1:0]};
      r_col    = place(sx_ff);
      r_row    = place(sy_ff);
      r_inside = fits(r_col) && fits(r_row);
      r_addr   = {r_row[CELL_W-1:0], r_col[CELL_W-1:0]};
      mem_we   = cmd.sweep || (cmd.step && d_inside);
      mem_wd   = cmd.sweep;
      w_addr   = cmd.sweep ? sweep_addr_ff : d_addr;
   end

   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      a_end_in    = a_end_ff;
      steep_in    = steep_ff;
      step_neg_in = step_neg_ff;
      p_in        = p_ff;
      inc_lo_in   = inc_lo_ff;
      inc_hi_in   = inc_hi_ff;
      count_in    = count_ff;
      if (cmd.setup) begin
         a_in        = as_v;
         b_in        = bs_v;
         a_end_in    = ae_v;
         steep_in    = steep;
         step_neg_in = !(bs_v < be_v);
         p_in        = two_minor - p_major;
         inc_lo_in   = two_minor;
         inc_hi_in   = two_minor - two_major;
         count_in    = '0;
      end else if (cmd.step) begin
         count_in = count_ff + COUNT_W'(d_inside);
         if (a_ff != a_end_ff) begin
            a_in = a_ff + CRD_W'(1);
            if (!p_ff[P_W-1] && (p_ff != '0)) begin
               b_in = step_neg_ff ? b_ff - CRD_W'(1) : b_ff + CRD_W'(1);
               p_in = p_ff + inc_hi_ff;
            end else begin
               p_in = p_ff + inc_lo_ff;
            end
         end
      end
   end

   assign sts.step_last  = a_ff == a_end_ff;
   assign sts.sweep_last = &sweep_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         occ_mem[w_addr] <= mem_wd;
      end
      rd_bit_ff <= occ_mem[r_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_addr_ff <= sweep_addr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         sx_ff   <= req_start_x;
         sy_ff   <= req_start_y;
         ex_ff   <= req_end_x;
         ey_ff   <= req_end_y;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      a_end_ff    <= a_end_in;
      steep_ff    <= steep_in;
      step_neg_ff <= step_neg_in;
      p_ff        <= p_in;
      inc_lo_ff   <= inc_lo_in;
      inc_hi_ff   <= inc_hi_in;
      count_ff    <= count_in;
      if (cmd.load_rsp) begin
         cell_free_ff     <= (kind_ff == KIND_READ) && r_inside && rd_bit_ff;
         cells_cleared_ff <= (kind_ff == KIND_DRAW) ? count_ff : '0;
      end
   end

   assign rsp_cell_free     = cell_free_ff;
   assign rsp_cells_cleared = cells_cleared_ff;

endmodule

`default_nettype wire

// ----- design/grid_line_rasterizer_top.sv -----
// top level of the grid line rasterizer
//
// req_bus takes one item at a time: kind 0 draws a segment between the start
// and end points, kind 1 reads the cell at the start point, kind 2 refills the
// map with ones. Points are cells relative to the map centre. rsp_bus returns
// one item per request: cell_free for a read, cells_cleared for a draw.
// Req ready is high only while the block is idle, so items are handled one at
// a time. A draw goes through a setup step and then the line stepper, one cell
// per cycle, and then to the response register. A read goes through the
// registered memory read port. A clear sweeps the whole bit memory one cell per
// cycle, 2^(2*clog2(MAP_SIDE)) cells (4096 at the default). After reset the
// same sweep runs with req ready low and gives no response. The response sits
// in an output register: a stalled receiver holds it while the next item is
// accepted and worked on, and that item waits only at its final step for the
// register.
`default_nettype none

module grid_line_rasterizer_top import glr_pkg::*; #(
   parameter int MAP_SIDE      = 64,
   parameter int CENTRE_OFFSET = 32
) (
   input wire logic clock,
   input wire logic reset,
   glr_req_if.sink  req_bus,
   glr_rsp_if.source rsp_bus
);

   glr_cmd_type cmd;
   glr_sts_type sts;
   logic        req_ready;
   logic        rsp_valid;

   glr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   glr_datapath #(
      .MAP_SIDE      (MAP_SIDE),
      .CENTRE_OFFSET (CENTRE_OFFSET)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_bus.kind),
      .req_start_x       (req_bus.start_x),
      .req_start_y       (req_bus.start_y),
      .req_end_x         (req_bus.end_x),
      .req_end_y         (req_bus.end_y),
      .rsp_cell_free     (rsp_bus.cell_free),
      .rsp_cells_cleared (rsp_bus.cells_cleared)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

`default_nettype wire

// ----- design/glr_checker.sv -----
// port level checks of the grid line rasterizer and their binding
`default_nettype none

module glr_checker import glr_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_cell_free,
   input wire logic [COUNT_W-1:0] rsp_cells_cleared
);

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in flight");

   // reset sweep keeps the block busy and silent
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready && !rsp_valid)
      else $error("block active right after reset");

   // a read result never carries a draw count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_free |-> rsp_cells_cleared == '0)
      else $error("response carries both a free bit and a count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_cell_free) && $stable(rsp_cells_cleared))
      else $error("response payload changed while stalled");

endmodule

bind grid_line_rasterizer_top glr_checker u_glr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_cell_free     (rsp_bus.cell_free),
   .rsp_cells_cleared (rsp_bus.cells_cleared)
);

`default_nettype wire

// ----- tb/sv/glr_checker.sv -----
// grid line rasterizer checker: watches both channels, predicts each response and compares
module glr_tb_checker import glr_pkg::*; #(
   parameter int MAP_SIDE      = 64,
   parameter int CENTRE_OFFSET = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   glr_req_if        req_mon,
   glr_rsp_if        rsp_mon,
   output int        fail_count,
   output int        owed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;

   typedef struct packed {
      logic               cell_free;
      logic [COUNT_W-1:0] cells_cleared;
   } glr_result_type;

   bit             free_map [MAP_CELLS];
   glr_result_type owed_results [$];
   int             errors = 0;

   initial begin
      foreach (free_map[i]) free_map[i] = 1'b1;
   end

   task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                  input logic [COUNT_W-1:0] want);
      $display("%0t: rsp %s: got %0d want %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic bit cell_slot(input int x, input int y, output int slot);
      int col;
      int row;
      col = x + CENTRE_OFFSET;
      row = y + CENTRE_OFFSET;
      slot = 0;
      if (col < 0 || col >= MAP_SIDE || row < 0 || row >= MAP_SIDE) return 1'b0;
      slot = row * MAP_SIDE + col;
      return 1'b1;
   endfunction

   function automatic int blank_cell(input int x, input int y);
      int slot;
      if (!cell_slot(x, y, slot)) return 0;
      free_map[slot] = 1'b0;
      return 1;
   endfunction

   // bresenham walk along the major axis, returns cells cleared inside the map
   function automatic int trace_segment(input int x1, input int y1, input int x2, input int y2);
      int dx, dy, a1, b1, a2, b2, major, minor, dir, err, a, b, t, hits;
      bit steep;
      dx = (x2 > x1) ? x2 - x1 : x1 - x2;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      steep = dx < dy;
      if (steep) begin
         a1 = y1; b1 = x1; a2 = y2; b2 = x2; major = dy; minor = dx;
      end else begin
         a1 = x1; b1 = y1; a2 = x2; b2 = y2; major = dx; minor = dy;
      end
      if (a1 > a2) begin
         t = a1; a1 = a2; a2 = t;
         t = b1; b1 = b2; b2 = t;
      end
      dir = (b1 < b2) ? 1 : -1;
      err = 2 * minor - major;
      a = a1;
      b = b1;
      hits = steep ? blank_cell(b, a) : blank_cell(a, b);
      while (a < a2) begin
         a++;
         if (err > 0) begin
            b += dir;
            err += 2 * minor - 2 * major;
         end else begin
            err += 2 * minor;
         end
         hits += steep ? blank_cell(b, a) : blank_cell(a, b);
      end
      return hits;
   endfunction

   always @(posedge clock) begin
      glr_result_type want;
      int slot;
      if (reset) begin
         foreach (free_map[i]) free_map[i] = 1'b1;
         owed_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("with no item outstanding", rsp_mon.cells_cleared, '0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_mon.cell_free !== want.cell_free)
                  report_mismatch("cell_free", COUNT_W'(rsp_mon.cell_free),
                                  COUNT_W'(want.cell_free));
               if (rsp_mon.cells_cleared !== want.cells_cleared)
                  report_mismatch("cells_cleared", rsp_mon.cells_cleared, want.cells_cleared);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want = '0;
            case (req_mon.kind)
               KIND_DRAW: begin
                  want.cells_cleared = COUNT_W'(trace_segment(int'(req_mon.start_x),
                                                              int'(req_mon.start_y),
                                                              int'(req_mon.end_x),
                                                              int'(req_mon.end_y)));
               end
               KIND_READ: begin
                  if (cell_slot(int'(req_mon.start_x), int'(req_mon.start_y), slot))
                     want.cell_free = free_map[slot];
               end
               KIND_CLEAR: begin
                  foreach (free_map[i]) free_map[i] = 1'b1;
               end
               default: ;
            endcase
            owed_results.push_back(want);
         end
      end
      owed_count <= owed_results.size();
      fail_count <= errors;
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// grid line rasterizer testbench top: clock, reset, item stimulus, response stalls and verdict
module tb_top import glr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic steady = 1'b0;
   int   stall_left = 0;
   int   fail_count;
   int   owed_count;
   logic signed [CRD_W-1:0] last_sx = '0, last_sy = '0, last_ex = '0, last_ey = '0;

   glr_req_if req_bus ();
   glr_rsp_if rsp_bus ();

   grid_line_rasterizer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   glr_tb_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_bus),
      .rsp_mon   (rsp_bus),
      .fail_count(fail_count),
      .owed_count(owed_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short pauses, a few long ones
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic signed [CRD_W-1:0] pick_coord();
      int v;
      if ($urandom_range(0, 99) < 80) v = int'($urandom_range(0, 79)) - 40;
      else v = $urandom_range(0, 127);
      return v[CRD_W-1:0];
   endfunction

   function automatic logic signed [CRD_W-1:0] nudge(input logic signed [CRD_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 6)) - 3;
      return v[CRD_W-1:0];
   endfunction

   always @(posedge clock) begin
      int pause;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         pause = pick_pause();
         rsp_bus.ready <= (pause == 0);
         stall_left <= (pause > 0) ? pause - 1 : 0;
      end
   end

   task automatic issue_item(input logic [KIND_W-1:0] kind,
                             input logic signed [CRD_W-1:0] sx, input logic signed [CRD_W-1:0] sy,
                             input logic signed [CRD_W-1:0] ex, input logic signed [CRD_W-1:0] ey);
      int pause;
      pause = pick_pause();
      if (pause > 0) begin
         req_bus.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.start_x <= sx;
      req_bus.start_y <= sy;
      req_bus.end_x   <= ex;
      req_bus.end_y   <= ey;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic issue_draw(input logic signed [CRD_W-1:0] sx, input logic signed [CRD_W-1:0] sy,
                             input logic signed [CRD_W-1:0] ex, input logic signed [CRD_W-1:0] ey);
      last_sx = sx;
      last_sy = sy;
      last_ex = ex;
      last_ey = ey;
      issue_item(KIND_DRAW, sx, sy, ex, ey);
   endtask

   initial begin
      int n;
      int r;
      logic signed [CRD_W-1:0] sx, sy, ex, ey;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_DRAW;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x = '0;
      req_bus.end_y = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, out of map, single point, axis lines, diagonals, no-op, clear
      issue_item(KIND_READ, 0, 0, 0, 0);
      issue_item(KIND_READ, -64, -64, 63, 63);
      issue_item(KIND_READ, 63, 63, -64, -64);
      issue_item(KIND_READ, -32, -32, 0, 0);
      issue_item(KIND_READ, 31, 31, 0, 0);
      issue_draw(0, 0, 0, 0);
      issue_item(KIND_READ, 0, 0, 0, 0);
      issue_draw(-32, 5, 31, 5);
      issue_draw(3, -64, 3, 63);
      issue_draw(-64, -64, 63, 63);
      issue_draw(63, -64, -64, 63);
      issue_draw(-64, 0, 63, 0);
      issue_draw(-10, -30, 5, 20);
      issue_draw(20, 10, -20, -5);
      issue_draw(40, 40, 63, 50);
      issue_draw(30, -2, -30, 2);
      issue_item(KIND_READ, 0, 5, 0, 0);
      issue_item(KIND_READ, 3, 40, 0, 0);
      issue_item(KIND_NOP, -64, 63, -64, 63);
      issue_item(KIND_NOP, 63, -64, 63, -64);
      issue_item(KIND_CLEAR, 0, 0, 0, 0);
      issue_item(KIND_READ, 0, 5, 0, 0);
      issue_item(KIND_READ, -32, -32, 0, 0);

      for (n = 0; n < 950; n++) begin
         steady <= (n >= 400 && n < 500);
         r = $urandom_range(0, 99);
         if (n % 50 == 49) begin
            issue_item(KIND_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_coord());
         end else if (r < 55) begin
            sx = pick_coord();
            sy = pick_coord();
            if ($urandom_range(0, 99) < 30) begin
               ex = nudge(sx);
               ey = nudge(sy);
            end else begin
               ex = pick_coord();
               ey = pick_coord();
            end
            issue_draw(sx, sy, ex, ey);
         end else if (r < 92) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
               sx = last_sx; sy = last_sy;
            end else if (r < 45) begin
               sx = last_ex; sy = last_ey;
            end else if (r < 80) begin
               sx = pick_coord(); sy = pick_coord();
            end else begin
               sx = CRD_W'($urandom_range(0, 127));
               sy = CRD_W'($urandom_range(0, 127));
            end
            issue_item(KIND_READ, sx, sy, CRD_W'($urandom_range(0, 127)),
                       CRD_W'($urandom_range(0, 127)));
         end else if (r < 97) begin
            issue_item(KIND_NOP, CRD_W'($urandom_range(0, 127)), CRD_W'($urandom_range(0, 127)),
                       CRD_W'($urandom_range(0, 127)), CRD_W'($urandom_range(0, 127)));
         end else begin
            issue_draw(CRD_W'($urandom_range(0, 127)), CRD_W'($urandom_range(0, 127)),
                       CRD_W'($urandom_range(0, 127)), CRD_W'($urandom_range(0, 127)));
         end
      end
      req_bus.valid <= 1'b0;
      steady <= 1'b0;

      do @(posedge clock); while (owed_count != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && owed_count == 0) begin
         $display("grid_line_rasterizer_top: match");
      end else begin
         $display("grid_line_rasterizer_top: mismatch");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("grid_line_rasterizer_top: mismatch");
      $finish;
   end

endmodule
